[src/lcdns_pkg.sv]
// ----------------------------------------------------------------------------
// lcdns_pkg
// Shared types, constants and tables for the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package lcdns_pkg;

  typedef enum logic [2:0] {
    CMD_INIT     = 3'd0,
    CMD_CLEAR    = 3'd1,
    CMD_DISP_OFF = 3'd2,
    CMD_DISP_ON  = 3'd3,
    CMD_MOVE     = 3'd4,
    CMD_PUT      = 3'd5
  } cmd_t;

  localparam int unsigned BEFORE_W = 14;
  localparam int unsigned AFTER_W  = 13;
  localparam int unsigned IDX_W    = 4;

  localparam logic [IDX_W-1:0] INIT_LAST_IDX = 4'd11;
  localparam logic [IDX_W-1:0] WAKE_STROBES  = 4'd4;

  localparam logic [7:0] BYTE_CLEAR    = 8'h01;
  localparam logic [7:0] BYTE_DISP_OFF = 8'h08;
  localparam logic [7:0] BYTE_DISP_ON  = 8'h0C;
  localparam logic [7:0] BYTE_FUNC_SET = 8'h28;
  localparam logic [7:0] BYTE_ENTRY    = 8'h06;
  localparam logic [7:0] BYTE_SET_ADDR = 8'h80;

  localparam logic [BEFORE_W-1:0] SETUP_US    = 14'd1;
  localparam logic [BEFORE_W-1:0] POWERUP_US  = 14'd15000;
  localparam logic [AFTER_W-1:0]  HOLD_US     = 13'd41;
  localparam logic [AFTER_W-1:0]  CLR_HOLD_US = 13'd2041;
  localparam logic [AFTER_W-1:0]  WAKE0_US    = 13'd4100;
  localparam logic [AFTER_W-1:0]  WAKE1_US    = 13'd100;
  localparam logic [AFTER_W-1:0]  WAKE2_US    = 13'd40;

  localparam logic [3:0] WAKE_NIB = 4'h3;
  localparam logic [3:0] MODE_NIB = 4'h2;

  typedef struct packed {
    logic                rs;
    logic [3:0]          nibble;
    logic [BEFORE_W-1:0] pre;
    logic [AFTER_W-1:0]  after;
    logic                last;
  } strobe_t;

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    case (row)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      default: base = 8'h54;
    endcase
    return base;
  endfunction

  function automatic logic [7:0] init_byte(input logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0:    b = BYTE_FUNC_SET;
      2'd1:    b = BYTE_DISP_OFF;
      2'd2:    b = BYTE_CLEAR;
      default: b = BYTE_ENTRY;
    endcase
    return b;
  endfunction

endpackage

[src/lcdns_if.sv]
// ----------------------------------------------------------------------------
// lcdns interfaces
// Valid/ready channels for command words and strobe words.
// ----------------------------------------------------------------------------
interface lcdns_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [1:0] row;
  logic [7:0] col;
  logic [7:0] character;

  modport source (output valid, cmd, row, col, character, input ready);
  modport sink (input valid, cmd, row, col, character, output ready);
endinterface

interface lcdns_strobe_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic [3:0]  nibble;
  logic [13:0] wait_before_us;
  logic [12:0] wait_after_us;
  logic        last;

  modport source (output valid, reg_select, nibble, wait_before_us, wait_after_us, last,
                  input ready);
  modport sink (input valid, reg_select, nibble, wait_before_us, wait_after_us, last,
                output ready);
endinterface

[src/char_lcd_nibble_sequencer_core.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core
// Turns LCD command words into 4-bit interface strobe words.
// ----------------------------------------------------------------------------
// a taken command is registered, then its first strobe word enters the result register
// throughput: one strobe word per cycle while the receiver is ready, set by the single
//   result register; unused codes are taken but send no strobe words
// a new command is taken in the cycle the previous command's last strobe is loaded
// reset: synchronous, clears the command and result valid flags only
module char_lcd_nibble_sequencer_core import lcdns_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  lcdns_cmd_if.sink     command,
  lcdns_strobe_if.source strobe
);

  logic             busy;
  cmd_t             cur_cmd;
  logic             cur_rs;
  logic [7:0]       cur_byte;
  logic [IDX_W-1:0] idx;

  cmd_t       in_cmd;
  logic       in_known;
  logic [7:0] in_byte;
  logic       take;
  logic       advance;
  logic       space;
  strobe_t    gen_strobe;

  assign in_cmd   = cmd_t'(command.cmd);
  assign in_known = (command.cmd <= CMD_PUT);
  assign advance  = busy && space;
  assign command.ready = !busy || (advance && gen_strobe.last);
  assign take     = command.valid && command.ready;

  always_comb begin
    case (in_cmd)
      CMD_CLEAR:    in_byte = BYTE_CLEAR;
      CMD_DISP_OFF: in_byte = BYTE_DISP_OFF;
      CMD_DISP_ON:  in_byte = BYTE_DISP_ON;
      CMD_MOVE:     in_byte = BYTE_SET_ADDR + row_base(command.row) + command.col;
      CMD_PUT:      in_byte = command.character;
      default:      in_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (take) begin
      busy <= in_known;
    end else if (advance && gen_strobe.last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_cmd  <= in_cmd;
      cur_rs   <= (in_cmd == CMD_PUT);
      cur_byte <= in_byte;
      idx      <= '0;
    end else if (advance) begin
      idx <= idx + 1'b1;
    end
  end

  lcdns_strobe_gen u_gen (
    .cmd       (cur_cmd),
    .rs        (cur_rs),
    .data_byte (cur_byte),
    .idx       (idx),
    .strobe    (gen_strobe)
  );

  lcdns_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance),
    .strobe_next (gen_strobe),
    .space       (space),
    .strobe      (strobe)
  );

`ifndef SYNTHESIS
  a_known_starts: assert property (@(posedge clk) disable iff (rst)
    take && in_known |=> busy && idx == '0)
    else $error("known command did not start");

  a_byte_idx: assert property (@(posedge clk) disable iff (rst)
    busy && cur_cmd != CMD_INIT |-> idx <= 4'd1)
    else $error("byte strobe index out of range");

  a_init_idx: assert property (@(posedge clk) disable iff (rst)
    busy && cur_cmd == CMD_INIT |-> idx <= INIT_LAST_IDX)
    else $error("init strobe index out of range");

  a_advance_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> strobe.valid && strobe.last == $past(gen_strobe.last))
    else $error("strobe word not registered");
`endif

endmodule

[src/lcdns_strobe_gen.sv]
// ----------------------------------------------------------------------------
// lcdns_strobe_gen
// Builds one enable strobe from the held command, its byte and strobe index.
// ----------------------------------------------------------------------------
module lcdns_strobe_gen import lcdns_pkg::*; (
  input  cmd_t             cmd,
  input  logic             rs,
  input  logic [7:0]       data_byte,
  input  logic [IDX_W-1:0] idx,
  output strobe_t          strobe
);

  logic [IDX_W-1:0] byte_idx;
  logic [7:0]       cur_byte;
  logic             clr_hold;

  always_comb begin
    byte_idx = idx - WAKE_STROBES;
    cur_byte = data_byte;
    clr_hold = (cmd == CMD_CLEAR);
    if (cmd == CMD_INIT) begin
      cur_byte = init_byte(byte_idx[2:1]);
      clr_hold = (cur_byte == BYTE_CLEAR);
    end
  end

  always_comb begin
    strobe.rs     = rs;
    strobe.nibble = idx[0] ? cur_byte[3:0] : cur_byte[7:4];
    strobe.pre    = idx[0] ? '0 : SETUP_US;
    strobe.after  = idx[0] ? (clr_hold ? CLR_HOLD_US : HOLD_US) : '0;
    strobe.last   = idx[0];
    if (cmd == CMD_INIT) begin
      strobe.last = (idx == INIT_LAST_IDX);
      if (idx < WAKE_STROBES) begin
        strobe.pre    = '0;
        strobe.nibble = WAKE_NIB;
        case (idx[1:0])
          2'd0: begin
            strobe.pre   = POWERUP_US;
            strobe.after = WAKE0_US;
          end
          2'd1:    strobe.after = WAKE1_US;
          2'd2:    strobe.after = WAKE2_US;
          default: begin
            strobe.after  = WAKE2_US;
            strobe.nibble = MODE_NIB;
          end
        endcase
      end
    end
  end

endmodule

[src/lcdns_out_reg.sv]
// ----------------------------------------------------------------------------
// lcdns_out_reg
// Result register driving the strobe channel.
// ----------------------------------------------------------------------------
module lcdns_out_reg import lcdns_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  strobe_t               strobe_next,
  output logic                  space,
  lcdns_strobe_if.source        strobe
);

  logic    valid;
  strobe_t data;

  assign space = !valid || strobe.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (strobe.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= strobe_next;
    end
  end

  assign strobe.valid          = valid;
  assign strobe.reg_select     = data.rs;
  assign strobe.nibble         = data.nibble;
  assign strobe.wait_before_us = data.pre;
  assign strobe.wait_after_us  = data.after;
  assign strobe.last           = data.last;

endmodule

[tb/char_lcd_nibble_sequencer_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core_test
// Sends LCD command words into the sequencer and checks every strobe word
// against a predicted queue. The predicted queue is built from each accepted
// command. The sender idles in random bursts and the receiver stalls on a
// rotating pattern. One long hold-off makes the block stall its command input.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core_test import lcdns_pkg::*; ();

  localparam logic [2:0] CMD_UNUSED_A = 3'd6;
  localparam logic [2:0] CMD_UNUSED_B = 3'd7;

  localparam logic [3:0]  NIB_WAKE    = 4'h3;
  localparam logic [3:0]  NIB_4BIT    = 4'h2;
  localparam logic [13:0] T_POWER_US  = 14'd15000;
  localparam logic [13:0] T_SETUP_US  = 14'd1;
  localparam logic [12:0] T_WAKE0_US  = 13'd4100;
  localparam logic [12:0] T_WAKE1_US  = 13'd100;
  localparam logic [12:0] T_WAKE2_US  = 13'd40;
  localparam logic [12:0] T_HOLD_US   = 13'd41;
  localparam logic [12:0] T_CLEAR_US  = 13'd2000;
  localparam logic [7:0]  INS_FUNC    = 8'h28;
  localparam logic [7:0]  INS_OFF     = 8'h08;
  localparam logic [7:0]  INS_ON      = 8'h0C;
  localparam logic [7:0]  INS_CLEAR   = 8'h01;
  localparam logic [7:0]  INS_ENTRY   = 8'h06;
  localparam logic [7:0]  INS_DDRAM   = 8'h80;

  localparam int unsigned HOLD_OFF_CYCLES = 90;
  localparam int unsigned DRAIN_CYCLES    = 30;
  localparam int unsigned CYCLE_LIMIT     = 250000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hold_go;
  int unsigned hold_cycles;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned burst_left = 0;
  bit gaps_enabled = 1'b1;
  logic [15:0] stall_pattern;
  int unsigned pattern_age;
  strobe_t expected_strobes[$];

  lcdns_cmd_if    command_bus ();
  lcdns_strobe_if strobe_bus ();

  char_lcd_nibble_sequencer_core dut (
    .clk     (clk),
    .rst     (rst),
    .command (command_bus),
    .strobe  (strobe_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  task automatic push_strobe(input logic rs, input logic [3:0] nib, input logic [13:0] pre,
                             input logic [12:0] post, input logic fin);
    strobe_t s;
    s.rs     = rs;
    s.nibble = nib;
    s.pre    = pre;
    s.after  = post;
    s.last   = fin;
    expected_strobes.push_back(s);
  endtask

  task automatic push_byte(input logic rs, input logic [7:0] b, input logic [12:0] extra,
                           input logic fin);
    push_strobe(rs, b[7:4], T_SETUP_US, 13'd0, 1'b0);
    push_strobe(rs, b[3:0], 14'd0, T_HOLD_US + extra, fin);
  endtask

  task automatic predict_strobes(input logic [2:0] code, input logic [1:0] row,
                                 input logic [7:0] col, input logic [7:0] chr);
    logic [7:0] base;
    case (row)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      default: base = 8'h54;
    endcase
    case (code)
      CMD_INIT: begin
        push_strobe(1'b0, NIB_WAKE, T_POWER_US, T_WAKE0_US, 1'b0);
        push_strobe(1'b0, NIB_WAKE, 14'd0, T_WAKE1_US, 1'b0);
        push_strobe(1'b0, NIB_WAKE, 14'd0, T_WAKE2_US, 1'b0);
        push_strobe(1'b0, NIB_4BIT, 14'd0, T_WAKE2_US, 1'b0);
        push_byte(1'b0, INS_FUNC, 13'd0, 1'b0);
        push_byte(1'b0, INS_OFF, 13'd0, 1'b0);
        push_byte(1'b0, INS_CLEAR, T_CLEAR_US, 1'b0);
        push_byte(1'b0, INS_ENTRY, 13'd0, 1'b1);
      end
      CMD_CLEAR:    push_byte(1'b0, INS_CLEAR, T_CLEAR_US, 1'b1);
      CMD_DISP_OFF: push_byte(1'b0, INS_OFF, 13'd0, 1'b1);
      CMD_DISP_ON:  push_byte(1'b0, INS_ON, 13'd0, 1'b1);
      // address sum truncates to eight bits
      CMD_MOVE:     push_byte(1'b0, INS_DDRAM + base + col, 13'd0, 1'b1);
      CMD_PUT:      push_byte(1'b1, chr, 13'd0, 1'b1);
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst && command_bus.valid && command_bus.ready)
      predict_strobes(command_bus.cmd, command_bus.row, command_bus.col, command_bus.character);
  end

  // ---------------------------------------------------------------- checker
  task automatic report_error(input string msg);
    $display("cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got)
      report_error($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
  endtask

  always @(posedge clk) begin
    strobe_t want;
    if (!rst && strobe_bus.valid && strobe_bus.ready) begin
      if (expected_strobes.size() == 0) begin
        report_error("strobe word arrived with none outstanding");
      end else begin
        want = expected_strobes.pop_front();
        check_field("reg_select", want.rs, strobe_bus.reg_select);
        check_field("nibble", want.nibble, strobe_bus.nibble);
        check_field("wait_before_us", want.pre, strobe_bus.wait_before_us);
        check_field("wait_after_us", want.after, strobe_bus.wait_after_us);
        check_field("last", want.last, strobe_bus.last);
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  initial begin
    hold_cycles = 0;
    forever begin
      @(posedge clk);
      if (hold_go)
        hold_cycles <= HOLD_OFF_CYCLES;
      else if (hold_cycles != 0)
        hold_cycles <= hold_cycles - 1;
    end
  end

  initial begin
    strobe_bus.ready = 1'b0;
    stall_pattern = 16'hFFFF;
    pattern_age = 0;
    forever begin
      @(posedge clk);
      strobe_bus.ready <= stall_pattern[0] && (hold_cycles == 0) && !hold_go;
      if (pattern_age == 47) begin
        pattern_age = 0;
        case ($urandom_range(0, 3))
          0:       stall_pattern = 16'hFFFF;
          1:       stall_pattern = 16'($urandom) | 16'h0001;
          2:       stall_pattern = 16'h0001;
          default: stall_pattern = 16'h5555;
        endcase
      end else begin
        pattern_age++;
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
    end
  end

  // ---------------------------------------------------------------- sender
  task automatic send_command(input logic [2:0] code, input logic [1:0] row,
                              input logic [7:0] col, input logic [7:0] chr);
    int unsigned gap;
    if (gaps_enabled && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      command_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    if (burst_left != 0)
      burst_left--;
    command_bus.valid     <= 1'b1;
    command_bus.cmd       <= code;
    command_bus.row       <= row;
    command_bus.col       <= col;
    command_bus.character <= chr;
    do @(posedge clk); while (!(command_bus.valid && command_bus.ready));
  endtask

  task automatic send_random_word();
    send_command(3'($urandom_range(0, 7)), 2'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_init_sequence();
    send_command(CMD_INIT, 2'd3, 8'hFF, 8'hFF);
  endtask

  task automatic test_fixed_instructions();
    send_command(CMD_CLEAR, 2'd0, 8'h00, 8'h00);
    send_command(CMD_DISP_OFF, 2'd1, 8'h55, 8'hAA);
    send_command(CMD_DISP_ON, 2'd2, 8'hAA, 8'h55);
  endtask

  task automatic test_cursor_moves();
    send_command(CMD_MOVE, 2'd0, 8'h00, 8'h00);
    send_command(CMD_MOVE, 2'd1, 8'hFF, 8'h00);
    // address wraps past the top of the range
    send_command(CMD_MOVE, 2'd2, 8'h6C, 8'hFF);
    send_command(CMD_MOVE, 2'd3, 8'h2C, 8'h00);
    send_command(CMD_MOVE, 2'd3, 8'hFF, 8'h00);
  endtask

  task automatic test_put_characters();
    send_command(CMD_PUT, 2'd0, 8'h00, 8'h00);
    send_command(CMD_PUT, 2'd3, 8'hFF, 8'hFF);
    send_command(CMD_PUT, 2'd1, 8'h12, 8'h5A);
  endtask

  task automatic test_unused_codes();
    send_command(CMD_UNUSED_A, 2'd2, 8'h80, 8'h7F);
    send_command(CMD_UNUSED_B, 2'd1, 8'h01, 8'hFE);
    send_command(CMD_PUT, 2'd0, 8'h00, 8'h41);
  endtask

  task automatic test_back_to_back();
    gaps_enabled = 1'b0;
    repeat (40) send_random_word();
    gaps_enabled = 1'b1;
  endtask

  task automatic test_receiver_hold_off();
    gaps_enabled = 1'b0;
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    repeat (24) send_random_word();
    gaps_enabled = 1'b1;
  endtask

  task automatic test_random_mix();
    repeat (130) send_random_word();
  endtask

  initial begin
    hold_go = 1'b0;
    command_bus.valid = 1'b0;
    command_bus.cmd = CMD_INIT;
    command_bus.row = 2'd0;
    command_bus.col = 8'h00;
    command_bus.character = 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_init_sequence();
    test_fixed_instructions();
    test_cursor_moves();
    test_put_characters();
    test_unused_codes();
    test_back_to_back();
    test_receiver_hold_off();
    test_random_mix();

    command_bus.valid <= 1'b0;
    while (expected_strobes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
